// ===== design/sit_pkg.sv =====
// Package for the sorted ID table: payload structs, operation and status codes.
// No dependencies; used by sorted_id_table and sit_checker.
package sit_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int ID_W          = 31;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_RANGE     = 2'd3;

   typedef struct packed {
      logic [1:0]      mode;
      logic [ID_W-1:0] id_value;
      logic [6:0]      read_index;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] read_data;
      logic [6:0]      position;
      logic [6:0]      moved;
      logic [7:0]      entry_count;
      logic [1:0]      status;
   } rsp_type;

endpackage

// ===== design/sit_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module sit_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sorted_id_table.sv =====
// Sorted ID table: top level, sequencer around one entry memory.
// Depends on sit_pkg and sit_ram.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------
//  req     | in        | req_valid/req_ready  | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//
// One transaction at a time, limited by the single memory read port walking
//   one entry per cycle. Insert walks down from the top and moves every larger
//   entry up; delete walks every stored entry; read fetches one entry; a
//   refused insert, out-of-range read or delete on an empty table goes straight
//   to the final state, which hands the result to the output register.
// Reset clears the count and control only; the memory needs no clearing since
//   entries at or above the count are never read.
// A new request is taken while the previous result still waits on rsp_ready;
//   it stalls only in its final state until the output register is free.
module sorted_id_table
   import sit_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INS_CMP = 3'd1;
   localparam logic [2:0] S_INS_PUT = 3'd2;
   localparam logic [2:0] S_DEL_CMP = 3'd3;
   localparam logic [2:0] S_RD_WAIT = 3'd4;
   localparam logic [2:0] S_FIN     = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [ID_W-1:0] val_ff, val_in;
   logic [CW-1:0]   idx_ff, idx_in;      // walking pointer
   logic [CW-1:0]   pos_ff, pos_in;      // delete hit position
   logic            found_ff, found_in;
   logic [CW-1:0]   count_ff, count_in;
   rsp_type         res_ff, res_in;      // result being built
   rsp_type         rsp_ff, rsp_in;      // output register
   logic            rsp_valid_ff, rsp_valid_in;

   // memory port signals
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [ID_W-1:0] wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [ID_W-1:0] rd_data;

   logic            hit;
   logic [CW-1:0]   del_pos;

   sit_ram #(
      .WIDTH (ID_W),
      .DEPTH (DEPTH)
   ) u_sit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hit     = (rd_data == val_ff);
   assign del_pos = found_ff ? pos_ff : idx_ff;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(idx_ff);
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in                = req_data.id_value;
               res_in                = '0;
               res_in.entry_count    = 8'(count_ff);
               case (req_data.mode)
                  MODE_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res_in.status = STATUS_FULL;
                        state_in      = S_FIN;
                     end else if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = S_INS_PUT;
                     end else begin
                        // walk down from the top entry
                        rd_en    = 1'b1;
                        rd_addr  = AW'(count_ff - CW'(1));
                        idx_in   = count_ff;
                        state_in = S_INS_CMP;
                     end
                  end
                  MODE_DELETE: begin
                     if (count_ff == '0) begin
                        res_in.status = STATUS_NOT_FOUND;
                        state_in      = S_FIN;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        found_in = 1'b0;
                        state_in = S_DEL_CMP;
                     end
                  end
                  default: begin
                     // read; mode three behaves the same
                     res_in.position = req_data.read_index;
                     if (32'(req_data.read_index) >= 32'(count_ff)) begin
                        res_in.status = STATUS_RANGE;
                        state_in      = S_FIN;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_data.read_index);
                        state_in = S_RD_WAIT;
                     end
                  end
               endcase
            end
         end

         S_INS_CMP: begin
            if (rd_data > val_ff) begin
               // shift entry idx-1 up one place
               wr_en   = 1'b1;
               wr_data = rd_data;
               if (idx_ff == CW'(1)) begin
                  idx_in   = '0;
                  state_in = S_INS_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(idx_ff - CW'(2));
                  idx_in  = idx_ff - CW'(1);
               end
            end else begin
               wr_en              = 1'b1;
               count_in           = count_ff + CW'(1);
               res_in.position    = 7'(idx_ff);
               res_in.moved       = 7'(count_ff - idx_ff);
               res_in.entry_count = 8'(count_ff + CW'(1));
               res_in.status      = STATUS_OK;
               state_in           = S_FIN;
            end
         end

         S_INS_PUT: begin
            wr_en              = 1'b1;
            count_in           = count_ff + CW'(1);
            res_in.position    = 7'(idx_ff);
            res_in.moved       = 7'(count_ff - idx_ff);
            res_in.entry_count = 8'(count_ff + CW'(1));
            res_in.status      = STATUS_OK;
            state_in           = S_FIN;
         end

         S_DEL_CMP: begin
            // once the hit is seen, every later entry moves down one place
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(idx_ff - CW'(1));
               wr_data = rd_data;
            end else if (hit) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
            end
            if (idx_ff == count_ff - CW'(1)) begin
               if (found_ff || hit) begin
                  count_in           = count_ff - CW'(1);
                  res_in.position    = 7'(del_pos);
                  res_in.moved       = 7'(count_ff - CW'(1) - del_pos);
                  res_in.entry_count = 8'(count_ff - CW'(1));
                  res_in.status      = STATUS_OK;
               end else begin
                  res_in.status = STATUS_NOT_FOUND;
               end
               state_in = S_FIN;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(idx_ff + CW'(1));
               idx_in  = idx_ff + CW'(1);
            end
         end

         S_RD_WAIT: begin
            res_in.read_data = rd_data;
            res_in.status    = STATUS_OK;
            state_in         = S_FIN;
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== design/sit_checker.sv =====
// Port-level checks for the sorted ID table, bound to the top level.
// Depends on sit_pkg and sorted_id_table.
module sit_checker
   import sit_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // result held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // one transaction at a time: input closes once a request is taken
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready still high after a request transaction");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |->
         rsp_data.entry_count == 8'(DEPTH) && rsp_data.position == '0 &&
         rsp_data.moved == '0 && rsp_data.read_data == '0)
      else $error("refused insert with table not full or fields set");

   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_NOT_FOUND |->
         rsp_data.position == '0 && rsp_data.moved == '0 &&
         rsp_data.read_data == '0)
      else $error("not-found delete reports a position or data");

endmodule

bind sorted_id_table sit_checker #(.DEPTH(DEPTH)) u_sit_checker (.*);
